[src/sle_pkg.sv]
// ---------------------------------------------------------------------------
// sle_pkg: shared types and codes of the sorted list engine
// Command and status codes, payload widths and the queue entry type.
// ---------------------------------------------------------------------------
package sle_pkg;

   localparam int unsigned CapacityDefault = 16;
   localparam int unsigned ValueWidth      = 32;
   localparam int unsigned CommandWidth    = 3;
   localparam int unsigned StatusWidth     = 2;
   localparam int unsigned LengthWidth     = 5;

   localparam logic [CommandWidth-1:0] CMD_INSERT = 3'd0;
   localparam logic [CommandWidth-1:0] CMD_DELETE = 3'd1;
   localparam logic [CommandWidth-1:0] CMD_LOOKUP = 3'd2;
   localparam logic [CommandWidth-1:0] CMD_CLEAR  = 3'd3;
   localparam logic [CommandWidth-1:0] CMD_REWIND = 3'd4;
   localparam logic [CommandWidth-1:0] CMD_READ   = 3'd5;

   localparam logic [StatusWidth-1:0] ST_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [StatusWidth-1:0] ST_FULL      = 2'd2;
   localparam logic [StatusWidth-1:0] ST_EMPTY     = 2'd3;

   // Decoded operation handed from front to back.
   typedef struct packed {
      logic              op_insert;
      logic              op_delete;
      logic              op_lookup;
      logic              op_clear;
      logic              op_rewind;
      logic              op_read;
      logic signed [ValueWidth-1:0] value;
   } op_type;

endpackage

[src/sle_if.sv]
// ---------------------------------------------------------------------------
// sle_req_if / sle_rsp_if: request and response channels
// Valid/ready channels carrying the request and result payloads.
// ---------------------------------------------------------------------------
interface sle_req_if;
   logic                                        valid;
   logic                                        ready;
   logic [sle_pkg::CommandWidth-1:0]            command;
   logic signed [sle_pkg::ValueWidth-1:0]       value;
   modport source (output valid, command, value, input ready);
   modport sink   (input valid, command, value, output ready);
endinterface

interface sle_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic [sle_pkg::StatusWidth-1:0]             status;
   logic                                        found;
   logic signed [sle_pkg::ValueWidth-1:0]       entry_value;
   logic [sle_pkg::LengthWidth-1:0]             length;
   modport source (output valid, status, found, entry_value, length, input ready);
   modport sink   (input valid, status, found, entry_value, length, output ready);
endinterface

[src/sorted_list_engine_core.sv]
// ---------------------------------------------------------------------------
// sorted_list_engine_core: sorted table of signed values
// Front end queues decoded requests; back end keeps the ordered cells.
// ---------------------------------------------------------------------------
// channel  | dir | signals
// req      | in  | valid, ready, command[2:0], value[31:0]
// rsp      | out | valid, ready, status[1:0], found, entry_value[31:0], length[4:0]
//
// One request per cycle sustained while the response is not stalled. A request
// waits in the front queue and the back end registers its result at the edge
// that pops it. The back end compares and shifts over all cells in parallel.
// Synchronous reset clears count, cursor and handshake state; cell contents are
// not cleared. A stalled response holds the back end, and the queue then fills
// and drops req_ready.
// ---------------------------------------------------------------------------
module sorted_list_engine_core #(
   parameter int unsigned CAPACITY = sle_pkg::CapacityDefault
) (
   input logic      clock,
   input logic      reset,
   sle_req_if.sink  req,
   sle_rsp_if.source rsp
);

   logic            q_valid, q_ready;
   sle_pkg::op_type q_op;

   sle_front u_front (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .req_command(req.command), .req_value(req.value),
      .q_valid, .q_ready, .q_op
   );

   sle_back #(.CAPACITY(CAPACITY)) u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_op,
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_status(rsp.status), .rsp_found(rsp.found),
      .rsp_entry_value(rsp.entry_value), .rsp_length(rsp.length)
   );

endmodule

[src/sle_front.sv]
// ---------------------------------------------------------------------------
// sle_front: request decode and two-entry queue
// Accepts requests, decodes the command and queues it for the back end.
// ---------------------------------------------------------------------------
module sle_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [sle_pkg::CommandWidth-1:0]      req_command,
   input  logic signed [sle_pkg::ValueWidth-1:0] req_value,
   output logic                q_valid,
   input  logic                q_ready,
   output sle_pkg::op_type     q_op
);

   sle_pkg::op_type slot_ff [2];
   sle_pkg::op_type dec;
   logic [1:0] fill_ff, fill_in;
   logic       wptr_ff, rptr_ff;
   logic       push, pop;

   // Decode the command into one-hot operation flags; undefined codes set none
   always_comb begin
      dec = '0;
      dec.value = req_value;
      unique case (req_command)
         sle_pkg::CMD_INSERT: dec.op_insert = 1'b1;
         sle_pkg::CMD_DELETE: dec.op_delete = 1'b1;
         sle_pkg::CMD_LOOKUP: dec.op_lookup = 1'b1;
         sle_pkg::CMD_CLEAR:  dec.op_clear  = 1'b1;
         sle_pkg::CMD_REWIND: dec.op_rewind = 1'b1;
         sle_pkg::CMD_READ:   dec.op_read   = 1'b1;
         default: ;
      endcase
   end

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_op      = slot_ff[rptr_ff];
   assign fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};

   // Advance queue pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
      end
   end

   // Hold queued payloads
   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= dec;
   end

endmodule

[src/sle_back.sv]
// ---------------------------------------------------------------------------
// sle_back: sorted cell array and result register
// Compares all cells in parallel, shifts on insert or delete, drives results.
// ---------------------------------------------------------------------------
module sle_back #(
   parameter int unsigned CAPACITY = sle_pkg::CapacityDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  sle_pkg::op_type     q_op,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [sle_pkg::StatusWidth-1:0]       rsp_status,
   output logic                                  rsp_found,
   output logic signed [sle_pkg::ValueWidth-1:0] rsp_entry_value,
   output logic [sle_pkg::LengthWidth-1:0]       rsp_length
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic signed [sle_pkg::ValueWidth-1:0] cell_ff [CAPACITY];
   logic signed [sle_pkg::ValueWidth-1:0] cell_in [CAPACITY];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [CAPACITY-1:0] lt_vec, eq_vec, valid_vec;
   logic [CAPACITY-1:0] del_mask;
   logic [CW-1:0] ins_pos;
   logic          hit;
   logic signed [sle_pkg::ValueWidth-1:0] read_val;
   logic [CW-1:0] rd_idx;
   logic          go;
   logic [sle_pkg::StatusWidth-1:0] st_in;
   logic          found_in;
   logic signed [sle_pkg::ValueWidth-1:0] ev_in;
   logic          full, empty;

   assign full    = (count_ff == CW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign q_ready = !rsp_valid || rsp_ready;
   assign go      = q_valid && q_ready;

   // Compare every live cell against the key
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid_vec[i] = (CW'(i) < count_ff);
         lt_vec[i]    = valid_vec[i] && (cell_ff[i] < q_op.value);
         eq_vec[i]    = valid_vec[i] && (cell_ff[i] == q_op.value);
      end
      ins_pos = CW'($countones(lt_vec));
      hit     = |eq_vec;
      // cells at or past the first match move down on delete
      del_mask[0] = eq_vec[0];
      for (int i = 1; i < CAPACITY; i++) del_mask[i] = del_mask[i-1] | eq_vec[i];
   end

   assign rd_idx   = (cursor_ff >= count_ff) ? '0 : cursor_ff;
   assign read_val = cell_ff[rd_idx[IW-1:0]];

   // Next state of cells, count, cursor and result
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) cell_in[i] = cell_ff[i];
      count_in  = count_ff;
      cursor_in = cursor_ff;
      st_in     = sle_pkg::ST_OK;
      found_in  = 1'b0;
      ev_in     = '0;
      priority if (q_op.op_insert) begin
         if (full) st_in = sle_pkg::ST_FULL;
         else begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (CW'(i) == ins_pos) cell_in[i] = q_op.value;
               else if (CW'(i) > ins_pos && i > 0) cell_in[i] = cell_ff[i-1];
            end
            count_in = count_ff + 1'b1;
         end
      end else if (q_op.op_delete || q_op.op_lookup) begin
         if (!hit) st_in = sle_pkg::ST_NOT_FOUND;
         else begin
            found_in = 1'b1;
            ev_in    = q_op.value;
            if (q_op.op_delete) begin
               for (int i = 0; i + 1 < CAPACITY; i++)
                  if (del_mask[i]) cell_in[i] = cell_ff[i+1];
               count_in = count_ff - 1'b1;
            end
         end
      end else if (q_op.op_clear) begin
         count_in  = '0;
         cursor_in = '0;
      end else if (q_op.op_rewind) begin
         cursor_in = '0;
      end else if (q_op.op_read) begin
         if (empty) st_in = sle_pkg::ST_EMPTY;
         else begin
            ev_in     = read_val;
            cursor_in = rd_idx + 1'b1;
         end
      end
   end

   // Update control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cursor_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (go) begin
            count_ff  <= count_in;
            cursor_ff <= cursor_in;
         end
         if (go) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   // Hold cells and result payload
   always_ff @(posedge clock) begin
      if (go) begin
         for (int i = 0; i < CAPACITY; i++) cell_ff[i] <= cell_in[i];
         rsp_status      <= st_in;
         rsp_found       <= found_in;
         rsp_entry_value <= ev_in;
         rsp_length      <= sle_pkg::LengthWidth'(count_in);
      end
   end

endmodule

[src/sle_checker.sv]
// ---------------------------------------------------------------------------
// sle_checker: port-level checks of the sorted list engine
// Watches the channels and flags protocol and result slips.
// ---------------------------------------------------------------------------
module sle_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [sle_pkg::StatusWidth-1:0] rsp_status,
   input logic rsp_found,
   input logic signed [sle_pkg::ValueWidth-1:0] rsp_entry_value,
   input logic [sle_pkg::LengthWidth-1:0] rsp_length
);

   // a stalled result stays valid and keeps its entry value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_value))
      else $error("result changed while stalled");

   // found only with ok status
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == sle_pkg::ST_OK)
      else $error("found with bad status");

   // empty report means zero length
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sle_pkg::ST_EMPTY |-> rsp_length == '0)
      else $error("empty status with entries");

   // full report means nonzero length
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sle_pkg::ST_FULL |-> rsp_length != '0)
      else $error("full status with no entries");

endmodule

bind sorted_list_engine_core sle_checker u_sle_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_found(rsp.found),
   .rsp_entry_value(rsp.entry_value), .rsp_length(rsp.length)
);

[tb/sv/sorted_list_engine_core_tb.sv]
// ---------------------------------------------------------------------------
// sorted_list_engine_core_tb: self-checking bench for the sorted list engine
// Walks directed requests, then random traffic with undefined codes too, and
// checks every response against an in-bench model of the ordered table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_engine_core_tb;

   localparam int unsigned Cap        = sle_pkg::CapacityDefault;
   localparam int unsigned NumRandom  = 700;
   localparam int unsigned CycleLimit = 200000;

   typedef struct packed {
      logic [sle_pkg::StatusWidth-1:0]        status;
      logic                                   found;
      logic signed [sle_pkg::ValueWidth-1:0]  entry_value;
      logic [sle_pkg::LengthWidth-1:0]        length;
   } rsp_type;

   typedef struct {
      logic [sle_pkg::CommandWidth-1:0]       command;
      logic signed [sle_pkg::ValueWidth-1:0]  value;
      bit                                     typed;
      rsp_type                                rsp;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sle_req_if req ();
   sle_rsp_if rsp ();

   sorted_list_engine_core #(.CAPACITY(Cap)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state of the table
   logic signed [sle_pkg::ValueWidth-1:0] tbl [Cap];
   int unsigned tbl_count  = 0;
   int unsigned tbl_cursor = 0;

   rsp_type   pending_rsp [$];
   int        errors = 0;
   int        cycles = 0;
   bit        quiet  = 1'b0;
   bit        hold_rsp = 1'b0;
   step_type  dir_table [$];

   function automatic int find_entry(logic signed [sle_pkg::ValueWidth-1:0] v);
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl[i] == v) return i;
         if (tbl[i] > v) break;
      end
      return -1;
   endfunction

   // advance the table model by one request and return the response it gives
   function automatic rsp_type apply_request(logic [sle_pkg::CommandWidth-1:0] cmd,
                                             logic signed [sle_pkg::ValueWidth-1:0] v);
      rsp_type r;
      int      pos;
      r = '0;
      case (cmd)
         sle_pkg::CMD_INSERT: begin
            if (tbl_count >= Cap) r.status = sle_pkg::ST_FULL;
            else begin
               pos = 0;
               while (pos < tbl_count && tbl[pos] < v) pos++;
               for (int i = tbl_count; i > pos; i--) tbl[i] = tbl[i-1];
               tbl[pos] = v;
               tbl_count++;
            end
         end
         sle_pkg::CMD_DELETE, sle_pkg::CMD_LOOKUP: begin
            pos = find_entry(v);
            if (pos < 0) r.status = sle_pkg::ST_NOT_FOUND;
            else begin
               r.found = 1'b1;
               r.entry_value = tbl[pos];
               if (cmd == sle_pkg::CMD_DELETE) begin
                  for (int i = pos; i + 1 < tbl_count; i++) tbl[i] = tbl[i+1];
                  tbl_count--;
               end
            end
         end
         sle_pkg::CMD_CLEAR: begin
            tbl_count  = 0;
            tbl_cursor = 0;
         end
         sle_pkg::CMD_REWIND: tbl_cursor = 0;
         sle_pkg::CMD_READ: begin
            if (tbl_count == 0) r.status = sle_pkg::ST_EMPTY;
            else begin
               if (tbl_cursor >= tbl_count) tbl_cursor = 0;
               r.entry_value = tbl[tbl_cursor];
               tbl_cursor++;
            end
         end
         default: ;
      endcase
      r.length = tbl_count[sle_pkg::LengthWidth-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   task automatic add_row(logic [sle_pkg::CommandWidth-1:0] c,
                          logic signed [sle_pkg::ValueWidth-1:0] v,
                          bit typed = 1'b0, rsp_type r = '0);
      step_type s;
      s.command = c; s.value = v; s.typed = typed; s.rsp = r;
      dir_table.push_back(s);
   endtask

   // drive one request and hold it until accepted
   task automatic send_request(logic [sle_pkg::CommandWidth-1:0] c,
                               logic signed [sle_pkg::ValueWidth-1:0] v,
                               bit typed, rsp_type want);
      rsp_type pred;
      int      gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.command <= c;
      req.value   <= v;
      do @(posedge clock); while (!req.ready);
      pred = apply_request(c, v);
      if (typed && pred != want)
         report_mismatch("table row", 64'(pred), 64'(want));
      pending_rsp.push_back(pred);
   endtask

   // choose a random request, often with a value already present
   task automatic random_request();
      logic [sle_pkg::CommandWidth-1:0]      c;
      logic signed [sle_pkg::ValueWidth-1:0] v;
      int                                    k;
      k = $urandom_range(0, 99);
      if (k < 35) c = sle_pkg::CMD_INSERT;
      else if (k < 55) c = sle_pkg::CMD_DELETE;
      else if (k < 72) c = sle_pkg::CMD_LOOKUP;
      else if (k < 75) c = sle_pkg::CMD_CLEAR;
      else if (k < 80) c = sle_pkg::CMD_REWIND;
      else if (k < 97) c = sle_pkg::CMD_READ;
      else c = sle_pkg::CommandWidth'($urandom_range(6, 7));
      k = $urandom_range(0, 9);
      if (k < 4 && tbl_count > 0) v = tbl[$urandom_range(0, tbl_count - 1)];
      else if (k < 7) v = $signed(sle_pkg::ValueWidth'($urandom_range(0, 15))) - 8;
      else v = $urandom;
      send_request(c, v, 1'b0, '0);
   endtask

   // stimulus
   initial begin
      rsp_type r;
      req.valid   <= 1'b0;
      req.command <= sle_pkg::CMD_INSERT;
      req.value   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      r = '0; r.status = sle_pkg::ST_EMPTY;
      add_row(sle_pkg::CMD_READ, 0, 1'b1, r);
      r = '0; r.status = sle_pkg::ST_NOT_FOUND;
      add_row(sle_pkg::CMD_LOOKUP, 5, 1'b1, r);
      r = '0; r.status = sle_pkg::ST_NOT_FOUND;
      add_row(sle_pkg::CMD_DELETE, 5, 1'b1, r);
      r = '0; r.length = sle_pkg::LengthWidth'(1);
      add_row(sle_pkg::CMD_INSERT, 32'sh7FFFFFFF, 1'b1, r);
      r = '0; r.length = sle_pkg::LengthWidth'(2);
      add_row(sle_pkg::CMD_INSERT, 32'sh80000000, 1'b1, r);
      add_row(sle_pkg::CMD_INSERT, 0);
      add_row(sle_pkg::CMD_INSERT, 0);
      add_row(sle_pkg::CMD_INSERT, -1);
      add_row(sle_pkg::CMD_READ, 0);
      add_row(sle_pkg::CMD_READ, 0);
      add_row(sle_pkg::CMD_LOOKUP, 32'sh80000000);
      add_row(sle_pkg::CMD_DELETE, 0);
      add_row(sle_pkg::CMD_READ, 0);
      add_row(sle_pkg::CMD_READ, 0);
      add_row(sle_pkg::CMD_READ, 0);
      add_row(sle_pkg::CMD_REWIND, 0);
      add_row(sle_pkg::CMD_READ, 0);
      add_row(3'd6, 32'shFFFFFFFF);
      add_row(3'd7, 0);
      r = '0;
      add_row(sle_pkg::CMD_CLEAR, 0, 1'b1, r);
      foreach (dir_table[i])
         send_request(dir_table[i].command, dir_table[i].value,
                      dir_table[i].typed, dir_table[i].rsp);

      // fill to capacity, then one refused insert and reads past the end
      for (int i = 0; i < Cap; i++) send_request(sle_pkg::CMD_INSERT, $urandom, 1'b0, '0);
      r = '0; r.status = sle_pkg::ST_FULL; r.length = sle_pkg::LengthWidth'(Cap);
      send_request(sle_pkg::CMD_INSERT, 1, 1'b1, r);
      for (int i = 0; i < Cap + 2; i++) send_request(sle_pkg::CMD_READ, 0, 1'b0, '0);

      for (int n = 0; n < NumRandom; n++) begin
         if (n == NumRandom - 100) quiet = 1'b1;
         random_request();
      end
      req.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("sorted_list_engine_core: match");
      else $display("sorted_list_engine_core: mismatch");
      $finish;
   end

   // long receiver hold-off while requests keep coming
   initial begin
      wait (!reset);
      repeat (200) @(posedge clock);
      hold_rsp = 1'b1;
      repeat (60) @(posedge clock);
      hold_rsp = 1'b0;
   end

   // response side: random stall bursts and checking
   initial begin
      int      stall;
      rsp_type got, want;
      rsp.ready <= 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            got.status = rsp.status; got.found = rsp.found;
            got.entry_value = rsp.entry_value; got.length = rsp.length;
            if (pending_rsp.size() == 0)
               report_mismatch("unexpected response", 64'(got), 64'(0));
            else begin
               want = pending_rsp.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               if (got.found != want.found)
                  report_mismatch("found", 64'(got.found), 64'(want.found));
               if (got.entry_value != want.entry_value)
                  report_mismatch("entry_value", 64'(got.entry_value),
                                  64'(want.entry_value));
               if (got.length != want.length)
                  report_mismatch("length", 64'(got.length), 64'(want.length));
            end
         end
         if (stall > 0) stall--;
         else if (!quiet && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 10);
         rsp.ready <= !reset && !hold_rsp && (stall == 0);
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("sorted_list_engine_core: mismatch");
         $finish;
      end
   end

endmodule
